>>> hw/rtl/bdt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdt_pkg
// Shared types and constants of the basic date-time string parser.
// ----------------------------------------------------------------------------
package bdt_pkg;

  localparam int unsigned PosW = 5;

  localparam logic [PosW-1:0] STR_LEN = PosW'(15);
  localparam logic [PosW-1:0] SEP_POS = PosW'(8);
  localparam logic [PosW-1:0] POS_SAT = PosW'(16);

  // end positions (exclusive) of the digit groups
  localparam logic [PosW-1:0] YEAR_HI_END = PosW'(2);
  localparam logic [PosW-1:0] YEAR_END    = PosW'(4);
  localparam logic [PosW-1:0] MONTH_END   = PosW'(6);
  localparam logic [PosW-1:0] DAY_END     = PosW'(8);
  localparam logic [PosW-1:0] HOUR_END    = PosW'(11);
  localparam logic [PosW-1:0] MINUTE_END  = PosW'(13);

  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [13:0] DEF_YEAR  = 14'd1900;
  localparam logic [3:0]  DEF_MONTH = 4'd1;
  localparam logic [4:0]  DEF_DAY   = 5'd1;

  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MIN_SEC_MAX = 7'd59;
  localparam logic [6:0] DAYS_31    = 7'd31;
  localparam logic [6:0] DAYS_30    = 7'd30;
  localparam logic [6:0] DAYS_29    = 7'd29;
  localparam logic [6:0] DAYS_28    = 7'd28;
  localparam logic [6:0] MONTH_FEB  = 7'd2;
  localparam logic [6:0] MONTH_APR  = 7'd4;
  localparam logic [6:0] MONTH_JUN  = 7'd6;
  localparam logic [6:0] MONTH_SEP  = 7'd9;
  localparam logic [6:0] MONTH_NOV  = 7'd11;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FORMAT   = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  // acc * 10 + d as shift-add, wrapped to the accumulator width
  function automatic logic [13:0] push_digit14(input logic [13:0] acc, input logic [3:0] d);
    push_digit14 = (acc << 3) + (acc << 1) + {10'd0, d};
  endfunction

  function automatic logic [6:0] push_digit7(input logic [6:0] acc, input logic [3:0] d);
    push_digit7 = (acc << 3) + (acc << 1) + {3'd0, d};
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bdt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdt_if
// Valid/ready channels of the date-time parser: characters in, results out.
// ----------------------------------------------------------------------------
interface bdt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface bdt_out_if;
  logic              valid;
  logic              ready;
  logic [13:0]       out_year;
  logic [3:0]        out_month;
  logic [4:0]        out_day;
  logic [4:0]        out_hour;
  logic [5:0]        out_minute;
  logic [5:0]        out_second;
  bdt_pkg::status_e  parse_status;

  modport source (output valid, output out_year, output out_month, output out_day,
                  output out_hour, output out_minute, output out_second,
                  output parse_status, input ready);
  modport sink   (input valid, input out_year, input out_month, input out_day,
                  input out_hour, input out_minute, input out_second,
                  input parse_status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/basic_datetime_string_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// basic_datetime_string_parser
// Parses YYYYMMDDTHHMMSS strings, one character per item, into a stored
// date-time with an accept / format reject / range reject status.
// ----------------------------------------------------------------------------
// One character is taken per cycle. Digits are folded into the field
// accumulators as they arrive; on the character flagged last the finished
// fields are copied to a snapshot register and the string state clears, so
// the next string may start in the following cycle. Once the result
// register is free, the snapshot is checked against the calendar and the
// result register, which also holds the stored date-time, is written. The
// stored value starts as 1900-01-01 00:00:00 after reset. Input ready drops
// only while a snapshot waits behind an unread result.
module basic_datetime_string_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bdt_in_if.sink    in_i,
  bdt_out_if.source out_o
);

  // string state
  logic [bdt_pkg::PosW-1:0] pos_q, pos_d;
  logic        fmt_q, fmt_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  yhi_q, yhi_d, ylo_q, ylo_d;
  logic [6:0]  month_q, month_d, day_q, day_d;
  logic [6:0]  hour_q, hour_d, minute_q, minute_d, second_q, second_d;

  // snapshot of a finished string
  logic        snap_valid_q;
  logic        snap_fmt_q;
  logic [13:0] snap_year_q;
  logic [6:0]  snap_yhi_q, snap_ylo_q, snap_month_q, snap_day_q;
  logic [6:0]  snap_hour_q, snap_minute_q, snap_second_q;

  // result / stored date-time
  logic             out_valid_q;
  logic [13:0]      kept_year_q;
  logic [3:0]       kept_month_q;
  logic [4:0]       kept_day_q, kept_hour_q;
  logic [5:0]       kept_minute_q, kept_second_q;
  bdt_pkg::status_e status_q;

  logic       in_fire, snap_adv, out_free;
  logic       is_digit;
  logic [3:0] digit;
  logic       leap;
  logic [6:0] max_day;
  logic       fields_ok;

  assign out_free = !out_valid_q || out_o.ready;
  assign snap_adv = snap_valid_q && out_free;
  assign in_i.ready = !snap_valid_q || snap_adv;
  assign in_fire = in_i.valid && in_i.ready;

  assign is_digit = (in_i.char_code >= bdt_pkg::CHAR_ZERO) &&
                    (in_i.char_code <= bdt_pkg::CHAR_NINE);
  assign digit = 4'(in_i.char_code - bdt_pkg::CHAR_ZERO);

  always_comb begin
    fmt_d    = fmt_q;
    year_d   = year_q;
    yhi_d    = yhi_q;
    ylo_d    = ylo_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    if (pos_q >= bdt_pkg::STR_LEN) begin
      fmt_d = 1'b0;
    end else if (pos_q == bdt_pkg::SEP_POS) begin
      if (in_i.char_code != bdt_pkg::CHAR_T) fmt_d = 1'b0;
    end else if (!is_digit) begin
      fmt_d = 1'b0;
    end else if (pos_q < bdt_pkg::YEAR_END) begin
      year_d = bdt_pkg::push_digit14(year_q, digit);
      // century and year-in-century kept apart for the leap test
      if (pos_q < bdt_pkg::YEAR_HI_END) yhi_d = bdt_pkg::push_digit7(yhi_q, digit);
      else ylo_d = bdt_pkg::push_digit7(ylo_q, digit);
    end else if (pos_q < bdt_pkg::MONTH_END) begin
      month_d = bdt_pkg::push_digit7(month_q, digit);
    end else if (pos_q < bdt_pkg::DAY_END) begin
      day_d = bdt_pkg::push_digit7(day_q, digit);
    end else if (pos_q < bdt_pkg::HOUR_END) begin
      hour_d = bdt_pkg::push_digit7(hour_q, digit);
    end else if (pos_q < bdt_pkg::MINUTE_END) begin
      minute_d = bdt_pkg::push_digit7(minute_q, digit);
    end else begin
      second_d = bdt_pkg::push_digit7(second_q, digit);
    end
    pos_d = (pos_q < bdt_pkg::POS_SAT) ? pos_q + bdt_pkg::PosW'(1) : bdt_pkg::POS_SAT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      fmt_q    <= 1'b1;
      year_q   <= '0;
      yhi_q    <= '0;
      ylo_q    <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
    end else if (in_fire) begin
      if (in_i.last_char) begin
        pos_q    <= '0;
        fmt_q    <= 1'b1;
        year_q   <= '0;
        yhi_q    <= '0;
        ylo_q    <= '0;
        month_q  <= '0;
        day_q    <= '0;
        hour_q   <= '0;
        minute_q <= '0;
        second_q <= '0;
      end else begin
        pos_q    <= pos_d;
        fmt_q    <= fmt_d;
        year_q   <= year_d;
        yhi_q    <= yhi_d;
        ylo_q    <= ylo_d;
        month_q  <= month_d;
        day_q    <= day_d;
        hour_q   <= hour_d;
        minute_q <= minute_d;
        second_q <= second_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (in_fire && in_i.last_char) begin
      snap_valid_q <= 1'b1;
    end else if (snap_adv) begin
      snap_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.last_char) begin
      snap_fmt_q    <= fmt_d && (pos_d == bdt_pkg::STR_LEN);
      snap_year_q   <= year_d;
      snap_yhi_q    <= yhi_d;
      snap_ylo_q    <= ylo_d;
      snap_month_q  <= month_d;
      snap_day_q    <= day_d;
      snap_hour_q   <= hour_d;
      snap_minute_q <= minute_d;
      snap_second_q <= second_d;
    end
  end

  // year % 4 follows the last two digits; a whole century follows the first two
  assign leap = (snap_ylo_q == 7'd0) ? (snap_yhi_q[1:0] == 2'd0) : (snap_ylo_q[1:0] == 2'd0);

  always_comb begin
    max_day = bdt_pkg::DAYS_31;
    if (snap_month_q == bdt_pkg::MONTH_APR || snap_month_q == bdt_pkg::MONTH_JUN ||
        snap_month_q == bdt_pkg::MONTH_SEP || snap_month_q == bdt_pkg::MONTH_NOV) begin
      max_day = bdt_pkg::DAYS_30;
    end else if (snap_month_q == bdt_pkg::MONTH_FEB) begin
      max_day = leap ? bdt_pkg::DAYS_29 : bdt_pkg::DAYS_28;
    end
  end

  assign fields_ok = (snap_month_q != 7'd0) && (snap_month_q <= bdt_pkg::MONTH_MAX) &&
                     (snap_day_q != 7'd0) && (snap_day_q <= max_day) &&
                     (snap_hour_q <= bdt_pkg::HOUR_MAX) &&
                     (snap_minute_q <= bdt_pkg::MIN_SEC_MAX) &&
                     (snap_second_q <= bdt_pkg::MIN_SEC_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      status_q      <= bdt_pkg::ST_ACCEPTED;
      kept_year_q   <= bdt_pkg::DEF_YEAR;
      kept_month_q  <= bdt_pkg::DEF_MONTH;
      kept_day_q    <= bdt_pkg::DEF_DAY;
      kept_hour_q   <= '0;
      kept_minute_q <= '0;
      kept_second_q <= '0;
    end else begin
      if (out_free) out_valid_q <= snap_valid_q;
      if (snap_adv) begin
        if (!snap_fmt_q) begin
          status_q <= bdt_pkg::ST_FORMAT;
        end else if (fields_ok) begin
          status_q      <= bdt_pkg::ST_ACCEPTED;
          kept_year_q   <= snap_year_q;
          kept_month_q  <= snap_month_q[3:0];
          kept_day_q    <= snap_day_q[4:0];
          kept_hour_q   <= snap_hour_q[4:0];
          kept_minute_q <= snap_minute_q[5:0];
          kept_second_q <= snap_second_q[5:0];
        end else begin
          status_q      <= bdt_pkg::ST_RANGE;
          kept_year_q   <= bdt_pkg::DEF_YEAR;
          kept_month_q  <= bdt_pkg::DEF_MONTH;
          kept_day_q    <= bdt_pkg::DEF_DAY;
          kept_hour_q   <= '0;
          kept_minute_q <= '0;
          kept_second_q <= '0;
        end
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_year     = kept_year_q;
  assign out_o.out_month    = kept_month_q;
  assign out_o.out_day      = kept_day_q;
  assign out_o.out_hour     = kept_hour_q;
  assign out_o.out_minute   = kept_minute_q;
  assign out_o.out_second   = kept_second_q;
  assign out_o.parse_status = status_q;

endmodule
`default_nettype wire

>>> tb/basic_datetime_string_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// basic_datetime_string_parser_tb
// Streams timestamp strings into the parser one character at a time and
// checks each result against a local model of the stored date-time, under
// random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module basic_datetime_string_parser_tb;

  localparam int unsigned TS_LEN       = 15;
  localparam int unsigned SEP_AT       = 8;
  localparam int unsigned POS_CAP      = 16;
  localparam logic [7:0]  CH_T         = 8'h54;
  localparam logic [7:0]  CH_0         = 8'h30;
  localparam logic [7:0]  CH_9         = 8'h39;
  localparam int unsigned RAND_CHARS   = 600;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AFTER   = 250;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] code;
    logic       is_last;
  } char_item_t;

  typedef struct {
    logic [13:0]      year;
    logic [3:0]       month;
    logic [4:0]       day;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
    bdt_pkg::status_e status;
  } stamp_t;

  typedef logic [7:0] char_q_t[$];

  logic clk_i;
  logic rst_ni;

  bdt_in_if  chr_if ();
  bdt_out_if res_if ();

  basic_datetime_string_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (chr_if),
    .out_o  (res_if)
  );

  // string state and stored date-time of the local model
  logic [4:0]  pos_q;
  logic        fmt_ok;
  logic [13:0] yr_acc;
  logic [6:0]  mo_acc, dy_acc, hr_acc, mi_acc, se_acc;
  stamp_t      kept;

  stamp_t      due_stamps[$];
  char_item_t  char_fifo[$];

  int unsigned total_chars  = 0;
  int unsigned chars_taken  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // handshake flags, set at the rising edge and consumed at the falling edge
  bit chr_taken = 0;
  bit res_taken = 0;
  bit hold_req  = 0;

  // driver and sink state
  char_item_t  cur_item;
  bit          drv_busy  = 0;
  int unsigned src_wait  = 0;
  int unsigned src_calm  = 0;
  int unsigned snk_wait  = 0;
  int unsigned snk_calm  = 0;
  int unsigned hold_left = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned month_days(int unsigned mo, int unsigned yr);
    bit leap;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    case (mo)
      4, 6, 9, 11: return 30;
      2:           return leap ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  function automatic bit calendar_ok();
    if (mo_acc < 1 || mo_acc > 12) return 1'b0;
    if (dy_acc < 1 || dy_acc > month_days(32'(mo_acc), 32'(yr_acc))) return 1'b0;
    if (hr_acc > 23 || mi_acc > 59 || se_acc > 59) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_string();
    pos_q  = '0;
    fmt_ok = 1'b1;
    yr_acc = '0;
    mo_acc = '0;
    dy_acc = '0;
    hr_acc = '0;
    mi_acc = '0;
    se_acc = '0;
  endfunction

  function automatic void set_epoch();
    kept.year   = 14'd1900;
    kept.month  = 4'd1;
    kept.day    = 5'd1;
    kept.hour   = '0;
    kept.minute = '0;
    kept.second = '0;
  endfunction

  // folds one accepted character into the model, queues a stamp on the last one
  function automatic void absorb_char(logic [7:0] c, logic is_last);
    int unsigned d;
    stamp_t res;
    d = 32'(c - CH_0);
    if (pos_q >= TS_LEN) begin
      fmt_ok = 1'b0;
    end else if (pos_q == SEP_AT) begin
      if (c != CH_T) fmt_ok = 1'b0;
    end else if (c < CH_0 || c > CH_9) begin
      fmt_ok = 1'b0;
    end else if (pos_q < 4) begin
      yr_acc = 14'(yr_acc * 10 + d);
    end else if (pos_q < 6) begin
      mo_acc = 7'(mo_acc * 10 + d);
    end else if (pos_q < 8) begin
      dy_acc = 7'(dy_acc * 10 + d);
    end else if (pos_q < 11) begin
      hr_acc = 7'(hr_acc * 10 + d);
    end else if (pos_q < 13) begin
      mi_acc = 7'(mi_acc * 10 + d);
    end else begin
      se_acc = 7'(se_acc * 10 + d);
    end
    if (pos_q < POS_CAP) pos_q = pos_q + 5'd1;
    if (is_last) begin
      if (!fmt_ok || pos_q != TS_LEN) begin
        kept.status = bdt_pkg::ST_FORMAT;
      end else if (calendar_ok()) begin
        kept.year   = yr_acc;
        kept.month  = mo_acc[3:0];
        kept.day    = dy_acc[4:0];
        kept.hour   = hr_acc[4:0];
        kept.minute = mi_acc[5:0];
        kept.second = se_acc[5:0];
        kept.status = bdt_pkg::ST_ACCEPTED;
      end else begin
        set_epoch();
        kept.status = bdt_pkg::ST_RANGE;
      end
      res = kept;
      due_stamps.push_back(res);
      clear_string();
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // zero waits come in runs now and then, otherwise a random wait is drawn
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic char_q_t to_chars(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  task automatic push_chars(input char_q_t q);
    char_item_t it;
    foreach (q[i]) begin
      it.code    = q[i];
      it.is_last = (i == q.size() - 1);
      char_fifo.push_back(it);
    end
    total_chars += q.size();
  endtask

  task automatic gen_string();
    int unsigned kind, yr, mo, dd, hh, mi, ss, keep_n;
    char_q_t q;
    kind = $urandom_range(0, 99);
    yr   = $urandom_range(0, 9999);
    mo   = $urandom_range(1, 12);
    dd   = $urandom_range(1, month_days(mo, yr));
    hh   = $urandom_range(0, 23);
    mi   = $urandom_range(0, 59);
    ss   = $urandom_range(0, 59);
    if (kind < 12) begin
      // end of february around the century leap rules
      case ($urandom_range(0, 5))
        0:       yr = 0;
        1:       yr = 100;
        2:       yr = 400;
        3:       yr = 1900;
        4:       yr = 2000;
        default: yr = $urandom_range(0, 2499) * 4;
      endcase
      mo = 2;
      dd = $urandom_range(28, 29);
    end else if (kind >= 55 && kind < 75) begin
      // one field out of range
      case ($urandom_range(0, 4))
        0: mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
        1: dd = $urandom_range(0, 1) ? 0 : $urandom_range(month_days(mo, yr) + 1, 99);
        2: hh = $urandom_range(24, 99);
        3: mi = $urandom_range(60, 99);
        default: ss = $urandom_range(60, 99);
      endcase
    end
    q = to_chars($sformatf("%04d%02d%02dT%02d%02d%02d", yr, mo, dd, hh, mi, ss));
    if (kind >= 75 && kind < 85) begin
      q[$urandom_range(0, TS_LEN - 1)] = 8'($urandom_range(0, 255));
    end else if (kind >= 85 && kind < 92) begin
      if ($urandom_range(0, 1)) begin
        keep_n = $urandom_range(1, TS_LEN - 1);
        while (q.size() > keep_n) void'(q.pop_back());
      end else begin
        repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(CH_0, CH_9)));
      end
    end else if (kind >= 92) begin
      q.delete();
      repeat ($urandom_range(1, 20)) q.push_back(8'($urandom_range(0, 255)));
    end
    push_chars(q);
  endtask

  // character driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (chr_taken) begin
        chr_taken = 0;
        drv_busy  = 0;
        src_wait  = draw_gap(src_calm);
      end
      if (!drv_busy) begin
        if (src_wait != 0) begin
          src_wait--;
        end else if (char_fifo.size() != 0) begin
          cur_item = char_fifo.pop_front();
          drv_busy = 1;
        end
      end
      chr_if.valid     <= drv_busy;
      chr_if.char_code <= cur_item.code;
      chr_if.last_char <= cur_item.is_last;
    end
  end

  // result sink
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        res_taken = 0;
        snk_wait  = draw_gap(snk_calm);
      end
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (snk_wait != 0) begin
        snk_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // monitor: feeds accepted characters to the model and checks results
  always @(posedge clk_i) begin
    stamp_t want;
    if (rst_ni) begin
      if (chr_if.valid && chr_if.ready) begin
        absorb_char(chr_if.char_code, chr_if.last_char);
        chars_taken++;
        chr_taken = 1;
      end
      if (res_if.valid && res_if.ready) begin
        res_taken = 1;
        if (due_stamps.size() == 0) begin
          $display("%0t: unexpected result, actual %0d-%0d-%0d %0d:%0d:%0d status %0d",
                   $time, res_if.out_year, res_if.out_month, res_if.out_day,
                   res_if.out_hour, res_if.out_minute, res_if.out_second,
                   res_if.parse_status);
          mismatch_cnt++;
        end else begin
          want = due_stamps.pop_front();
          check_field("year",   16'(want.year),   16'(res_if.out_year));
          check_field("month",  16'(want.month),  16'(res_if.out_month));
          check_field("day",    16'(want.day),    16'(res_if.out_day));
          check_field("hour",   16'(want.hour),   16'(res_if.out_hour));
          check_field("minute", 16'(want.minute), 16'(res_if.out_minute));
          check_field("second", 16'(want.second), 16'(res_if.out_second));
          check_field("status", 16'(want.status), 16'(res_if.parse_status));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d characters taken, %0d results due",
               $time, chars_taken, total_chars, due_stamps.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    chr_if.valid     = 1'b0;
    chr_if.char_code = '0;
    chr_if.last_char = 1'b0;
    res_if.ready     = 1'b0;
    cur_item         = '0;
    clear_string();
    set_epoch();
    kept.status = bdt_pkg::ST_ACCEPTED;

    // leap year zero with the latest time of day
    push_chars(to_chars("00000229T235959"));
    // lone top character: too short, stored value kept
    push_chars({8'hFF});
    // 9999 is no leap year: range reject back to the default
    push_chars(to_chars("99990229T000000"));
    push_chars({8'h00});
    while (total_chars < RAND_CHARS + 32) gen_string();

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // long output stall with the sender still busy
    while (chars_taken < HOLD_AFTER) @(negedge clk_i);
    @(posedge clk_i);
    hold_req = 1;

    while (!(chars_taken == total_chars && due_stamps.size() == 0)) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
